### rtl/rfbd_pkg.sv
// Shared types and constants for the run-length frame store decoder.
package rfbd_pkg;

  localparam int unsigned StoreBytesDef = 504;
  localparam int unsigned DataW         = 8;
  localparam int unsigned ReadAddrW     = 9;
  localparam int unsigned InTdataW      = 24;
  localparam int unsigned OutTdataW     = 16;

  // Request kind on the slave side (tuser).
  localparam logic CmdImage = 1'b0;
  localparam logic CmdRead  = 1'b1;

  // Result kind on the master side (tuser).
  localparam logic KindStatus = 1'b0;
  localparam logic KindRead   = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFill,
    StRead,
    StStatus,
    StResult
  } state_e;

  typedef struct packed {
    logic             kind;
    logic             ok;
    logic [DataW-1:0] data;
  } result_t;

endpackage

### rtl/rfbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 504,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rfbd_ctrl.sv
// Decode sequencer: run parsing, store fill, clearing pass, reads and status.
module rfbd_ctrl import rfbd_pkg::*; #(
  parameter int unsigned STORE_BYTES = StoreBytesDef,
  localparam int unsigned IdxW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_cmd_i,
  input  logic [DataW-1:0]     in_data_i,
  input  logic                 in_last_i,
  input  logic [ReadAddrW-1:0] in_addr_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output result_t              res_o,
  output logic                 mem_we_o,
  output logic [IdxW-1:0]      mem_waddr_o,
  output logic [DataW-1:0]     mem_wdata_o,
  output logic                 mem_re_o,
  output logic [IdxW-1:0]      mem_raddr_o,
  input  logic [DataW-1:0]     mem_rdata_i
);

  // Pointer holds 0..STORE_BYTES; sums and compares need one more bit.
  localparam int unsigned PtrW = $clog2(STORE_BYTES + 1);
  localparam int unsigned SumW = ((PtrW > DataW) ? PtrW : DataW) + 1;
  localparam int unsigned CmpW = (PtrW > ReadAddrW) ? PtrW : ReadAddrW;

  state_e           state_q, state_d;
  logic [PtrW-1:0]  wp_q, wp_d;
  logic [DataW-1:0] pend_q, pend_d;
  logic             exp_q, exp_d;
  logic             fail_q, fail_d;
  logic             last_q, last_d;
  logic [DataW-1:0] val_q, val_d;
  logic             rdok_q, rdok_d;
  result_t          res_q, res_d;

  always_comb begin
    logic go_fill;
    go_fill     = 1'b0;
    state_d     = state_q;
    wp_d        = wp_q;
    pend_d      = pend_q;
    exp_d       = exp_q;
    fail_d      = fail_q;
    last_d      = last_q;
    val_d       = val_q;
    rdok_d      = rdok_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q[IdxW-1:0];
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = IdxW'(in_addr_i);

    unique case (state_q)
      StClear: begin
        // Zero one store byte per cycle after reset.
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
        if (wp_q == PtrW'(STORE_BYTES - 1)) begin
          wp_d    = '0;
          state_d = StIdle;
        end else begin
          wp_d = wp_q + PtrW'(1);
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CmdRead) begin
            mem_re_o = 1'b1;
            rdok_d   = CmpW'(in_addr_i) < CmpW'(STORE_BYTES);
            state_d  = StRead;
          end else begin
            last_d = in_last_i;
            if (!fail_q) begin
              if (!exp_q) begin
                if ((in_data_i == '0) ||
                    (SumW'(wp_q) + SumW'(in_data_i) > SumW'(STORE_BYTES))) begin
                  fail_d = 1'b1;
                end else begin
                  pend_d = in_data_i;
                  exp_d  = 1'b1;
                end
              end else begin
                val_d   = in_data_i;
                go_fill = 1'b1;
              end
            end
            if (go_fill) begin
              state_d = StFill;
            end else if (in_last_i) begin
              state_d = StStatus;
            end
          end
        end
      end
      StFill: begin
        // One store write per cycle until the run is spent.
        mem_we_o = 1'b1;
        wp_d     = wp_q + PtrW'(1);
        pend_d   = pend_q - DataW'(1);
        if (pend_q == DataW'(1)) begin
          exp_d   = 1'b0;
          state_d = last_q ? StStatus : StIdle;
        end
      end
      StRead: begin
        res_d.kind = KindRead;
        res_d.ok   = 1'b0;
        res_d.data = rdok_q ? mem_rdata_i : '0;
        state_d    = StResult;
      end
      StStatus: begin
        res_d.kind = KindStatus;
        res_d.ok   = !fail_q && !exp_q && (wp_q == PtrW'(STORE_BYTES));
        res_d.data = '0;
        // Rearm for the next image; the store keeps its contents.
        wp_d       = '0;
        pend_d     = '0;
        exp_d      = 1'b0;
        fail_d     = 1'b0;
        state_d    = StResult;
      end
      StResult: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      wp_q    <= '0;
      pend_q  <= '0;
      exp_q   <= 1'b0;
      fail_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      pend_q  <= pend_d;
      exp_q   <= exp_d;
      fail_q  <= fail_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rdok_q <= rdok_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

### rtl/rle_frame_buffer_decoder_top.sv
// Top level of the run-length frame store decoder.
//
// The block takes a compressed image as a stream of (count, value) byte pairs
// and fills a frame store of STORE_BYTES bytes from a running write pointer.
// The byte flagged with tlast ends the image: it returns one status result
// (decode_ok high only if the image filled the store exactly, with no zero
// count, no overlong run and an even length) and rearms the decoder. After a
// failure the remaining bytes of the image are dropped until the last one;
// pairs decoded before the failure stay written. A read request (tuser high)
// returns one store byte, or zero for an address beyond the store.
// After reset a clearing pass zeroes the store, one byte a cycle, and no
// request is taken until it ends. A count byte is only registered. A value
// byte starts a fill that writes the run one byte a cycle, since the run
// goes through the single write port of the store RAM. The last byte adds a
// status step and a hand-off of the result to the output register. A read
// goes through issue, registered RAM read and result. The hand-off stretches
// for as long as the output register is still full. A finished result waits
// in the output register, so the next request is taken while the result is
// still held on the master side.
module rle_frame_buffer_decoder_top import rfbd_pkg::*; #(
  parameter int unsigned STORE_BYTES = StoreBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: data_byte [7:0], read_address [16:8], zero fill
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // tuser: cmd
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: decode_ok [0], read_data [8:1], zero fill
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // tuser: result_kind
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i
);

  localparam int unsigned IdxW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic             res_valid;
  logic             res_ready;
  result_t          res;

  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  // Frame store.
  rfbd_ram #(
    .Width (DataW),
    .Depth (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Run parser, fill sequencer and read/status path.
  rfbd_ctrl #(
    .STORE_BYTES (STORE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i[7:0]),
    .in_last_i   (s_axis_tlast_i),
    .in_addr_i   (s_axis_tdata_i[16:8]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: load when empty or when the held result is taken.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {(OutTdataW - DataW - 1)'(0), out_q.data, out_q.ok};

endmodule

### tb/sv/rle_frame_buffer_decoder_top_tb.sv
// Self-checking testbench for the run-length frame store decoder top level.
module rle_frame_buffer_decoder_top_tb;
  import rfbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreBytes  = StoreBytesDef;
  localparam int unsigned AddrTop     = (1 << ReadAddrW) - 1;
  localparam int unsigned RandomItems = 1900;
  // Longest fill is 255 bytes, plus the count, value and status steps.
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 4_000_000;
  // Two long receiver hold-offs, placed well inside the traffic.
  localparam int unsigned HoldStartA  = 2_000;
  localparam int unsigned HoldStartB  = 12_000;
  localparam int unsigned HoldCycles  = 400;

  typedef struct {
    logic                 cmd;
    logic [DataW-1:0]     byte_val;
    logic                 last;
    logic [ReadAddrW-1:0] addr;
  } request_t;

  typedef enum int {
    ImgGood,
    ImgShort,
    ImgLong,
    ImgZeroCount,
    ImgOverrun,
    ImgOdd,
    ImgNoise
  } image_e;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 s_tlast  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OutTdataW-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  request_t          request_q [$];
  result_t           replies_due_q [$];
  logic [DataW-1:0]  image_bytes_q [$];
  bit                mix_reads;
  int unsigned       err_cnt;
  int unsigned       cycle_cnt;

  // Decoder mirror: store contents and the decode state of the image in flight.
  logic [DataW-1:0]  frame_mirror [StoreBytes];
  int unsigned       fill_ptr;
  logic [DataW-1:0]  run_len;
  bit                want_value;
  bit                image_bad;

  request_t          offered;
  int unsigned       send_pct;
  int unsigned       idle_left;
  int unsigned       recv_pct;
  int unsigned       stall_left;

  rle_frame_buffer_decoder_top #(
    .STORE_BYTES(StoreBytes)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // Idle rate for the next window: none, light or heavy.
  function automatic int unsigned pick_pct();
    int unsigned sel;
    sel = $urandom_range(0, 2);
    return (sel == 0) ? 0 : ((sel == 1) ? 10 : 35);
  endfunction

  function automatic logic [ReadAddrW-1:0] pick_read_addr();
    return ($urandom_range(0, 15) == 0) ? ReadAddrW'($urandom_range(StoreBytes, AddrTop))
                                        : ReadAddrW'($urandom_range(0, StoreBytes - 1));
  endfunction

  // Advance the mirror by one accepted request and queue the result it causes.
  task automatic mirror_request(input request_t rq);
    result_t r;
    if (rq.cmd == CmdRead) begin
      r.kind = KindRead;
      r.ok   = 1'b0;
      r.data = (rq.addr < StoreBytes) ? frame_mirror[rq.addr] : '0;
      replies_due_q.push_back(r);
    end else begin
      // A failed image drops everything up to its last byte.
      if (!image_bad) begin
        if (!want_value) begin
          if (rq.byte_val == 0 || fill_ptr >= StoreBytes ||
              fill_ptr + rq.byte_val > StoreBytes) begin
            image_bad = 1'b1;
          end else begin
            run_len    = rq.byte_val;
            want_value = 1'b1;
          end
        end else begin
          for (int i = 0; i < run_len; i++) frame_mirror[fill_ptr + i] = rq.byte_val;
          fill_ptr   += run_len;
          run_len    = '0;
          want_value = 1'b0;
        end
      end
      if (rq.last) begin
        r.kind = KindStatus;
        r.ok   = !image_bad && !want_value && fill_ptr == StoreBytes;
        r.data = '0;
        replies_due_q.push_back(r);
        // Rearm; the store keeps its contents.
        fill_ptr   = 0;
        run_len    = '0;
        want_value = 1'b0;
        image_bad  = 1'b0;
      end
    end
  endtask

  task automatic queue_read(input logic [ReadAddrW-1:0] addr);
    request_t rq;
    rq.cmd      = CmdRead;
    rq.byte_val = DataW'($urandom_range(0, 255));
    rq.last     = 1'($urandom_range(0, 1));
    rq.addr     = addr;
    request_q.push_back(rq);
  endtask

  // Send the staged image bytes, marking the final one, with reads mixed in when mix_reads is set.
  task automatic flush_image();
    request_t rq;
    foreach (image_bytes_q[i]) begin
      if (mix_reads && $urandom_range(0, 7) == 0) queue_read(pick_read_addr());
      rq.cmd      = CmdImage;
      rq.byte_val = image_bytes_q[i];
      rq.last     = (i == image_bytes_q.size() - 1);
      rq.addr     = ReadAddrW'($urandom_range(0, AddrTop));
      request_q.push_back(rq);
    end
    image_bytes_q.delete();
  endtask

  // Stage an image of the given shape: well-formed pairs up to a target fill,
  // then whatever tail its shape calls for, then send it.
  task automatic queue_image(input image_e flavour);
    int unsigned target, done, cap, cnt, tail;
    cap  = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(60, 255);
    done = 0;
    case (flavour)
      ImgGood, ImgLong:     target = StoreBytes;
      ImgShort:             target = $urandom_range(1, StoreBytes - 1);
      ImgZeroCount, ImgOdd: target = $urandom_range(0, StoreBytes - 1);
      ImgOverrun:           target = $urandom_range(StoreBytes - 254, StoreBytes - 1);
      default:              target = 0;
    endcase
    while (done < target) begin
      cnt = $urandom_range(1, (cap < target - done) ? cap : target - done);
      image_bytes_q.push_back(DataW'(cnt));
      image_bytes_q.push_back(DataW'($urandom_range(0, 255)));
      done += cnt;
    end
    case (flavour)
      ImgZeroCount: begin
        image_bytes_q.push_back('0);
        tail = $urandom_range(0, 4);
      end
      ImgOverrun: begin
        image_bytes_q.push_back(DataW'($urandom_range(StoreBytes - target + 1, 255)));
        tail = $urandom_range(0, 4);
      end
      ImgOdd: begin
        cnt = StoreBytes - target;
        image_bytes_q.push_back(DataW'($urandom_range(1, (cnt < 255) ? cnt : 255)));
        tail = 0;
      end
      ImgLong:  tail = $urandom_range(1, 5);
      ImgNoise: tail = $urandom_range(1, 12);
      default:  tail = 0;
    endcase
    repeat (tail) image_bytes_q.push_back(DataW'($urandom_range(0, 255)));
    flush_image();
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, replies_due_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Sender: offer queued requests, idle at random after each accepted one.
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (cycle_cnt % 256 == 0) send_pct = pick_pct();
      if (s_tvalid && s_tready) begin
        mirror_request(offered);
        idle_left = ($urandom_range(0, 99) < send_pct) ? pick_gap() : 0;
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          offered = request_q.pop_front();
          s_tdata  <= {{(InTdataW - DataW - ReadAddrW){1'b0}}, offered.addr, offered.byte_val};
          s_tuser  <= offered.cmd;
          s_tlast  <= offered.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs so the output register
  // stays full and the block has to stall its input.
  always @(posedge clk_i) begin : receiver
    if (rst_ni) begin
      if (cycle_cnt % 256 == 0) recv_pct = pick_pct();
      if (cycle_cnt == HoldStartA || cycle_cnt == HoldStartB) begin
        stall_left = HoldCycles;
      end else if (stall_left == 0 && $urandom_range(0, 99) < recv_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest one due.
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (replies_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0b tdata %0h",
                 $time, m_tuser, m_tdata);
        err_cnt++;
      end else begin
        want = replies_due_q.pop_front();
        check_field("result_kind", DataW'(want.kind), DataW'(m_tuser));
        check_field("decode_ok", DataW'(want.ok), DataW'(m_tdata[0]));
        check_field("read_data", want.data, m_tdata[8:1]);
      end
    end
  end

  initial begin
    foreach (frame_mirror[i]) frame_mirror[i] = '0;

    // Directed: reset contents, exact fill with the widest counts, then
    // one image for each way an image can fail.
    mix_reads = 1'b0;
    queue_read('0);
    queue_read(ReadAddrW'(AddrTop));
    image_bytes_q = '{8'd255, 8'hff, 8'd249, 8'h00};
    flush_image();
    queue_read(ReadAddrW'(254));
    queue_read(ReadAddrW'(255));
    // Zero count.
    image_bytes_q = '{8'd0, 8'hab};
    flush_image();
    // Odd length; the decoded pair stays written.
    image_bytes_q = '{8'd5, 8'h5a, 8'd3};
    flush_image();
    queue_read('0);
    // Run past the end, then bytes that must be dropped.
    image_bytes_q = '{8'd255, 8'h11, 8'd250, 8'h33};
    flush_image();
    // Store full before the stream ends.
    image_bytes_q = '{8'd252, 8'h77, 8'd252, 8'h88, 8'd1, 8'h99};
    flush_image();
    queue_read(ReadAddrW'(StoreBytes - 1));
    // Stream ends before the store is full.
    image_bytes_q = '{8'd10, 8'h44};
    flush_image();

    // Random: mostly well-formed images with reads mixed in, the rest broken.
    mix_reads = 1'b1;
    while (request_q.size() < RandomItems) begin
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)      queue_image(ImgGood);
      else if (sel < 63) queue_image(ImgShort);
      else if (sel < 70) queue_image(ImgLong);
      else if (sel < 77) queue_image(ImgZeroCount);
      else if (sel < 84) queue_image(ImgOverrun);
      else if (sel < 91) queue_image(ImgOdd);
      else               queue_image(ImgNoise);
      repeat ($urandom_range(0, 3)) queue_read(pick_read_addr());
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: hold until every request is taken and every result has come.
    while (request_q.size() != 0 || s_tvalid || replies_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (replies_due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, replies_due_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rfbd_pkg.sv
rtl/rfbd_ram.sv
rtl/rfbd_ctrl.sv
rtl/rle_frame_buffer_decoder_top.sv
tb/sv/rle_frame_buffer_decoder_top_tb.sv
